FILE: design/rpc_pkg.sv
// shared constants, types and helper functions for the point rotation block
package rpc_pkg;

  localparam int unsigned DEF_ITERATIONS  = 20;
  localparam int unsigned DEF_COORD_WIDTH = 24;

  localparam int unsigned ANGLE_W    = 24;
  localparam int unsigned GUARD_BITS = 24;
  localparam int unsigned WORK_EXTRA = 26;
  localparam int unsigned ZW         = 34;
  localparam int unsigned GAIN_W     = 24;
  localparam logic [GAIN_W-1:0] GAIN_Q24 = GAIN_W'(10188014);

  // angle reduction: 360 degrees = 92160 = 45 * 2^11
  localparam int unsigned UW    = ANGLE_W + 1;
  localparam int unsigned LOW_W = 11;
  localparam int unsigned H_W   = UW - LOW_W;
  localparam logic [UW-1:0] ANGLE_OFS = UW'(8478720);
  localparam int unsigned DW     = 15;
  localparam int unsigned QW     = 10;
  localparam int unsigned RMW    = 6;
  localparam int unsigned RECIP45 = 1456;

  localparam int unsigned R_W = 18;
  localparam logic signed [R_W-1:0] R_TURN     = R_W'(92160);
  localparam logic signed [R_W-1:0] R_HALF     = R_W'(46080);
  localparam logic signed [R_W-1:0] R_QUARTER  = R_W'(23040);
  localparam logic signed [R_W-1:0] R_NQUARTER = -R_W'(23040);

  localparam int unsigned ZFRAC_W   = 21;
  localparam int unsigned ZFRAC_N   = 45;
  localparam int unsigned ATAN_COUNT = 31;

  typedef struct packed {
    logic [QW-1:0]  q;
    logic [RMW-1:0] r;
  } div45_t;

  typedef logic [ZFRAC_W-1:0] zfrac_tab_t [ZFRAC_N];

  localparam logic [31:0] ATAN_TAB [ATAN_COUNT] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001
  };

  function automatic zfrac_tab_t build_zfrac();
    zfrac_tab_t t;
    for (int i = 0; i < ZFRAC_N; i++) begin
      t[i] = ZFRAC_W'((longint'(i) * 64'd2097152 + 64'd22) / 45);
    end
    return t;
  endfunction

  // fraction part of degrees to binary angle units, one entry per remainder
  localparam zfrac_tab_t ZFRAC = build_zfrac();

  function automatic logic [ZW-1:0] atan_step(input int unsigned i);
    logic [ZW-1:0] s;
    s = '0;
    if (i < ATAN_COUNT) begin
      s = ZW'(ATAN_TAB[i]);
    end
    return s;
  endfunction

  // quotient estimate by 45, exact or one low
  function automatic logic [QW-1:0] div45_est(input logic [DW-1:0] v);
    logic [25:0] p;
    p = 26'(v) * 26'(RECIP45);
    return p[25:16];
  endfunction

  function automatic div45_t div45_fix(input logic [DW-1:0] v, input logic [QW-1:0] q);
    logic [DW-1:0] r;
    div45_t res;
    r = v - DW'(q) * DW'(45);
    if (r >= DW'(45)) begin
      res.q = q + QW'(1);
      res.r = RMW'(r - DW'(45));
    end else begin
      res.q = q;
      res.r = RMW'(r);
    end
    return res;
  endfunction

endpackage

FILE: design/rpc_in_if.sv
// input channel carrying point, center and angle
interface rpc_in_if #(
  parameter int unsigned COORD_WIDTH = rpc_pkg::DEF_COORD_WIDTH
);
  import rpc_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic signed [ANGLE_W-1:0]     angle;

  modport source (output valid, point_x, point_y, center_x, center_y, angle, input ready);
  modport sink   (input valid, point_x, point_y, center_x, center_y, angle, output ready);
endinterface

FILE: design/rpc_out_if.sv
// output channel carrying the rotated point
interface rpc_out_if #(
  parameter int unsigned COORD_WIDTH = rpc_pkg::DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] rot_x;
  logic signed [COORD_WIDTH-1:0] rot_y;
  logic                          overflow;

  modport source (output valid, rot_x, rot_y, overflow, input ready);
  modport sink   (input valid, rot_x, rot_y, overflow, output ready);
endinterface

FILE: design/rotate_point_about_center_top.sv
// top level of the pipelined cordic point rotation about a center
//
// in_i takes one item per cycle: a point, a center (signed Q16.8) and an
// angle in 1/256 degree, positive counter-clockwise. out_o gives the rotated
// point, saturated to the coordinate range, with overflow set when either
// coordinate clipped. one result per item, in order.
// pipeline: 6 prep stages, one cell per cordic iteration, 2 output stages.
// throughput: one item per cycle, set by the fully pipelined cell chain.
// the whole pipeline advances when the output register is empty or taken;
// while the receiver stalls with a result waiting, in_i.ready drops and
// every stage holds. reset clears all stage valid bits; no clearing pass.
module rotate_point_about_center_top #(
  parameter int unsigned ITERATIONS  = rpc_pkg::DEF_ITERATIONS,
  parameter int unsigned COORD_WIDTH = rpc_pkg::DEF_COORD_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rpc_in_if.sink    in_i,
  rpc_out_if.source out_o
);
  import rpc_pkg::*;

  localparam int unsigned WW = COORD_WIDTH + WORK_EXTRA;

  logic adv;

  logic                         vc  [ITERATIONS+1];
  logic signed [WW-1:0]         xc  [ITERATIONS+1];
  logic signed [WW-1:0]         yc  [ITERATIONS+1];
  logic signed [ZW-1:0]         zc  [ITERATIONS+1];
  logic signed [COORD_WIDTH-1:0] cxc [ITERATIONS+1];
  logic signed [COORD_WIDTH-1:0] cyc [ITERATIONS+1];

  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  rpc_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (in_i.valid),
    .point_x_i  (in_i.point_x),
    .point_y_i  (in_i.point_y),
    .center_x_i (in_i.center_x),
    .center_y_i (in_i.center_y),
    .angle_i    (in_i.angle),
    .valid_o    (vc[0]),
    .x_o        (xc[0]),
    .y_o        (yc[0]),
    .z_o        (zc[0]),
    .cx_o       (cxc[0]),
    .cy_o       (cyc[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    rpc_cell #(
      .COORD_WIDTH(COORD_WIDTH),
      .STEP       (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (vc[i]),
      .x_i     (xc[i]),
      .y_i     (yc[i]),
      .z_i     (zc[i]),
      .cx_i    (cxc[i]),
      .cy_i    (cyc[i]),
      .valid_o (vc[i+1]),
      .x_o     (xc[i+1]),
      .y_o     (yc[i+1]),
      .z_o     (zc[i+1]),
      .cx_o    (cxc[i+1]),
      .cy_o    (cyc[i+1])
    );
  end

  rpc_post #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (vc[ITERATIONS]),
    .x_i        (xc[ITERATIONS]),
    .y_i        (yc[ITERATIONS]),
    .cx_i       (cxc[ITERATIONS]),
    .cy_i       (cyc[ITERATIONS]),
    .valid_o    (out_o.valid),
    .rot_x_o    (out_o.rot_x),
    .rot_y_o    (out_o.rot_y),
    .overflow_o (out_o.overflow)
  );

endmodule

FILE: design/rpc_prep.sv
// front pipeline: offsets, gain scaling, angle reduction and folding
module rpc_prep #(
  parameter int unsigned COORD_WIDTH = rpc_pkg::DEF_COORD_WIDTH
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  logic signed [COORD_WIDTH-1:0]                 point_x_i,
  input  logic signed [COORD_WIDTH-1:0]                 point_y_i,
  input  logic signed [COORD_WIDTH-1:0]                 center_x_i,
  input  logic signed [COORD_WIDTH-1:0]                 center_y_i,
  input  logic signed [rpc_pkg::ANGLE_W-1:0]            angle_i,
  output logic                                          valid_o,
  output logic signed [COORD_WIDTH+rpc_pkg::WORK_EXTRA-1:0] x_o,
  output logic signed [COORD_WIDTH+rpc_pkg::WORK_EXTRA-1:0] y_o,
  output logic signed [rpc_pkg::ZW-1:0]                 z_o,
  output logic signed [COORD_WIDTH-1:0]                 cx_o,
  output logic signed [COORD_WIDTH-1:0]                 cy_o
);
  import rpc_pkg::*;

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned WW     = CW + WORK_EXTRA;
  localparam int unsigned STAGES = 6;

  logic [STAGES-1:0] valid_q;

  // stage 1
  logic signed [CW:0]   dx1_q, dy1_q;
  logic [H_W-1:0]       h1_q;
  logic [LOW_W-1:0]     lo1_q;
  logic [UW-1:0]        u1;
  // stage 2
  logic signed [WW-1:0] x2_q, y2_q;
  logic [H_W-1:0]       h2_q;
  logic [LOW_W-1:0]     lo2_q;
  logic [QW-1:0]        qh2_q;
  // stage 3
  logic signed [WW-1:0] x3_q, y3_q;
  logic signed [R_W-1:0] rs3_d, rs3_q;
  div45_t               fh;
  logic [RMW+LOW_W-1:0] r0;
  // stage 4
  logic signed [WW-1:0] x4_d, y4_d, x4_q, y4_q;
  logic signed [R_W-1:0] rf, rabs;
  logic                 neg;
  logic [DW-1:0]        mag4_q;
  logic                 sgn4_q;
  // stage 5
  logic signed [WW-1:0] x5_q, y5_q;
  logic [DW-1:0]        mag5_q;
  logic [QW-1:0]        qm5_q;
  logic                 sgn5_q;
  // stage 6
  logic signed [WW-1:0] x6_q, y6_q;
  logic signed [ZW-1:0] z6_d, z6_q;
  logic [ZW-1:0]        zm;
  div45_t               fm;

  logic signed [CW-1:0] cx_q [STAGES];
  logic signed [CW-1:0] cy_q [STAGES];

  assign u1 = {angle_i[ANGLE_W-1], angle_i} + ANGLE_OFS;

  always_comb begin
    fh    = div45_fix(DW'(h2_q), qh2_q);
    r0    = {fh.r, lo2_q};
    rs3_d = $signed({1'b0, r0});
    if (rs3_d > R_HALF) begin
      rs3_d = rs3_d - R_TURN;
    end
  end

  always_comb begin
    neg = 1'b0;
    rf  = rs3_q;
    if (rs3_q > R_QUARTER) begin
      neg = 1'b1;
      rf  = rs3_q - R_HALF;
    end else if (rs3_q < R_NQUARTER) begin
      neg = 1'b1;
      rf  = rs3_q + R_HALF;
    end
    rabs = rf[R_W-1] ? -rf : rf;
    x4_d = neg ? -x3_q : x3_q;
    y4_d = neg ? -y3_q : y3_q;
  end

  always_comb begin
    fm   = div45_fix(mag5_q, qm5_q);
    zm   = ZW'({fm.q, {ZFRAC_W{1'b0}}}) + ZW'(ZFRAC[fm.r]);
    z6_d = sgn5_q ? -$signed(zm) : $signed(zm);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx1_q  <= {point_x_i[CW-1], point_x_i} - {center_x_i[CW-1], center_x_i};
      dy1_q  <= {point_y_i[CW-1], point_y_i} - {center_y_i[CW-1], center_y_i};
      h1_q   <= u1[UW-1:LOW_W];
      lo1_q  <= u1[LOW_W-1:0];

      x2_q   <= dx1_q * $signed({1'b0, GAIN_Q24});
      y2_q   <= dy1_q * $signed({1'b0, GAIN_Q24});
      h2_q   <= h1_q;
      lo2_q  <= lo1_q;
      qh2_q  <= div45_est(DW'(h1_q));

      x3_q   <= x2_q;
      y3_q   <= y2_q;
      rs3_q  <= rs3_d;

      x4_q   <= x4_d;
      y4_q   <= y4_d;
      mag4_q <= rabs[DW-1:0];
      sgn4_q <= rf[R_W-1];

      x5_q   <= x4_q;
      y5_q   <= y4_q;
      mag5_q <= mag4_q;
      qm5_q  <= div45_est(mag4_q);
      sgn5_q <= sgn4_q;

      x6_q   <= x5_q;
      y6_q   <= y5_q;
      z6_q   <= z6_d;

      cx_q[0] <= center_x_i;
      cy_q[0] <= center_y_i;
      for (int i = 1; i < STAGES; i++) begin
        cx_q[i] <= cx_q[i-1];
        cy_q[i] <= cy_q[i-1];
      end
    end
  end

  assign valid_o = valid_q[STAGES-1];
  assign x_o     = x6_q;
  assign y_o     = y6_q;
  assign z_o     = z6_q;
  assign cx_o    = cx_q[STAGES-1];
  assign cy_o    = cy_q[STAGES-1];

endmodule

FILE: design/rpc_cell.sv
// one cordic micro-rotation cell of the rotation chain
module rpc_cell #(
  parameter int unsigned COORD_WIDTH = rpc_pkg::DEF_COORD_WIDTH,
  parameter int unsigned STEP        = 0
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic                                              valid_i,
  input  logic signed [COORD_WIDTH+rpc_pkg::WORK_EXTRA-1:0] x_i,
  input  logic signed [COORD_WIDTH+rpc_pkg::WORK_EXTRA-1:0] y_i,
  input  logic signed [rpc_pkg::ZW-1:0]                     z_i,
  input  logic signed [COORD_WIDTH-1:0]                     cx_i,
  input  logic signed [COORD_WIDTH-1:0]                     cy_i,
  output logic                                              valid_o,
  output logic signed [COORD_WIDTH+rpc_pkg::WORK_EXTRA-1:0] x_o,
  output logic signed [COORD_WIDTH+rpc_pkg::WORK_EXTRA-1:0] y_o,
  output logic signed [rpc_pkg::ZW-1:0]                     z_o,
  output logic signed [COORD_WIDTH-1:0]                     cx_o,
  output logic signed [COORD_WIDTH-1:0]                     cy_o
);
  import rpc_pkg::*;

  localparam int unsigned WW = COORD_WIDTH + WORK_EXTRA;
  localparam logic signed [ZW-1:0] ANG = atan_step(STEP);

  logic signed [WW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  logic signed [COORD_WIDTH-1:0] cx_q, cy_q;
  logic                 valid_q;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (!z_i[ZW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ANG;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ANG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= x_d;
      y_q  <= y_d;
      z_q  <= z_d;
      cx_q <= cx_i;
      cy_q <= cy_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign cx_o    = cx_q;
  assign cy_o    = cy_q;

endmodule

FILE: design/rpc_post.sv
// rounding, center add-back, saturation and output register
module rpc_post #(
  parameter int unsigned COORD_WIDTH = rpc_pkg::DEF_COORD_WIDTH
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic                                              valid_i,
  input  logic signed [COORD_WIDTH+rpc_pkg::WORK_EXTRA-1:0] x_i,
  input  logic signed [COORD_WIDTH+rpc_pkg::WORK_EXTRA-1:0] y_i,
  input  logic signed [COORD_WIDTH-1:0]                     cx_i,
  input  logic signed [COORD_WIDTH-1:0]                     cy_i,
  output logic                                              valid_o,
  output logic signed [COORD_WIDTH-1:0]                     rot_x_o,
  output logic signed [COORD_WIDTH-1:0]                     rot_y_o,
  output logic                                              overflow_o
);
  import rpc_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned WW = CW + WORK_EXTRA;
  localparam int unsigned SW = CW + 3;
  localparam logic signed [WW-1:0] ROUND = WW'(1) <<< (GUARD_BITS - 1);
  localparam logic [CW-1:0] SAT_HI = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SAT_LO = {1'b1, {(CW-1){1'b0}}};

  logic signed [WW-1:0] xr, yr;
  logic signed [CW+1:0] xa_q, ya_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic [1:0]           valid_q;
  logic signed [SW-1:0] sx, sy;
  logic                 ox, oy;
  logic signed [CW-1:0] rx_d, ry_d, rx_q, ry_q;
  logic                 ovf_q;

  assign xr = x_i + ROUND;
  assign yr = y_i + ROUND;

  always_comb begin
    sx   = {xa_q[CW+1], xa_q} + {{3{cx_q[CW-1]}}, cx_q};
    sy   = {ya_q[CW+1], ya_q} + {{3{cy_q[CW-1]}}, cy_q};
    ox   = !((sx[SW-1:CW-1] == '0) || (sx[SW-1:CW-1] == '1));
    oy   = !((sy[SW-1:CW-1] == '0) || (sy[SW-1:CW-1] == '1));
    rx_d = ox ? (sx[SW-1] ? SAT_LO : SAT_HI) : sx[CW-1:0];
    ry_d = oy ? (sy[SW-1] ? SAT_LO : SAT_HI) : sy[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q  <= xr[WW-1:GUARD_BITS];
      ya_q  <= yr[WW-1:GUARD_BITS];
      cx_q  <= cx_i;
      cy_q  <= cy_i;
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      ovf_q <= ox | oy;
    end
  end

  assign valid_o    = valid_q[1];
  assign rot_x_o    = rx_q;
  assign rot_y_o    = ry_q;
  assign overflow_o = ovf_q;

endmodule
